// ===== rtl/wsfd_pkg.sv =====
package wsfd_pkg;

    // status codes reported on the last byte of a buffer
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_OVERRUN   = 2'd2;
    localparam logic [1:0] ST_BAD_OP    = 2'd3;

    // header field constants
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;

    // opcodes accepted as ok
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_start;
        logic       buffer_end;
    } wsfd_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        is_payload;
        logic        header_done;
        logic        fin_bit;
        logic [3:0]  frame_opcode;
        logic        masked;
        logic [31:0] payload_length;
        logic        status_valid;
        logic [1:0]  status;
    } wsfd_result_t;

    function automatic logic opcode_known(input logic [3:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
               (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

// ===== rtl/websocket_frame_deframer_core.sv =====
// channel | direction | handshake           | payload
// --------+-----------+---------------------+-----------------------------------------
// in      | input     | in_valid / in_ready | in_byte, buffer_start, buffer_end
// out     | output    | out_valid/out_ready | payload_byte ... status (one per byte)
//
// one item per cycle sustained while the output is not stalled; an accepted input item reaches the output
// through the input register, then header/unmask logic into the result register
// the 64-bit remaining-count decrement in the payload phase sets the cycle time
// rst_n clears valid flags and the parser state (phase back to first header byte)
// a stalled output holds its result while one more item waits in the input register
module websocket_frame_deframer_core
#(
    parameter int LENGTH_OUT_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        buffer_start,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic        is_payload,
    output logic        header_done,
    output logic        fin_bit,
    output logic [3:0]  frame_opcode,
    output logic        masked,
    output logic [31:0] payload_length,
    output logic        status_valid,
    output logic [1:0]  status
);

    // length bits kept on the port, capped at the port width
    localparam int KEEP_BITS = (LENGTH_OUT_BITS < 32) ? LENGTH_OUT_BITS : 32;
    localparam logic [31:0] LEN_MASK = 32'((33'd1 << KEEP_BITS) - 33'd1);

    wsfd_pkg::wsfd_item_t   in_item;
    wsfd_pkg::wsfd_item_t   item;
    wsfd_pkg::wsfd_result_t parse_result;
    wsfd_pkg::wsfd_result_t load_result;
    wsfd_pkg::wsfd_result_t result;
    logic                   item_valid;
    logic                   can_load;
    logic                   fire;

    assign in_item.in_byte      = in_byte;
    assign in_item.buffer_start = buffer_start;
    assign in_item.buffer_end   = buffer_end;

    // input register
    wsfd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (can_load),
        .item_valid (item_valid),
        .item       (item)
    );

    // parser state advances only when the item moves into the result register
    assign fire = item_valid && can_load;

    wsfd_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (parse_result)
    );

    always_comb
    begin
        load_result                = parse_result;
        load_result.payload_length = parse_result.payload_length & LEN_MASK;
    end

    // result register
    wsfd_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (item_valid),
        .load_result (load_result),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

    assign payload_byte   = result.payload_byte;
    assign is_payload     = result.is_payload;
    assign header_done    = result.header_done;
    assign fin_bit        = result.fin_bit;
    assign frame_opcode   = result.frame_opcode;
    assign masked         = result.masked;
    assign payload_length = result.payload_length;
    assign status_valid   = result.status_valid;
    assign status         = result.status;

endmodule

// ===== rtl/wsfd_in_stage.sv =====
module wsfd_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wsfd_pkg::wsfd_item_t in_item,
    input  logic                take,
    output logic                item_valid,
    output wsfd_pkg::wsfd_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    wsfd_pkg::wsfd_item_t item_reg;

    // stage frees up when empty or when its item moves on this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/wsfd_parser.sv =====
module wsfd_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  wsfd_pkg::wsfd_item_t  item,
    output wsfd_pkg::wsfd_result_t result
);

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_PAY  = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    phase_t      phase_reg,      phase_next, phase_cur;
    logic [3:0]  ext_count_reg,  ext_count_next;
    logic        fin_reg,        fin_next;
    logic [3:0]  opcode_reg,     opcode_next;
    logic        mask_reg,       mask_next;
    logic [63:0] length_reg,     length_next;
    logic [31:0] mask_key_reg,   mask_key_next;
    logic [1:0]  key_index_reg,  key_index_next;
    logic [63:0] remaining_reg,  remaining_next;

    logic [7:0]  b;
    logic [1:0]  key_sel;
    logic [7:0]  key_byte;
    logic [3:0]  ext_dec;
    logic [1:0]  key_inc;
    logic        before_hdr;
    logic        after_hdr;
    logic        still_hdr;

    assign b = item.in_byte;

    always_comb
    begin
        phase_cur      = item.buffer_start ? PH_HDR0 : phase_reg;
        phase_next     = phase_cur;
        ext_count_next = ext_count_reg;
        fin_next       = fin_reg;
        opcode_next    = opcode_reg;
        mask_next      = mask_reg;
        length_next    = length_reg;
        mask_key_next  = mask_key_reg;
        key_index_next = key_index_reg;
        remaining_next = remaining_reg;
        key_sel        = 2'd3 - key_index_reg;
        key_byte       = mask_reg ? mask_key_reg[{key_sel, 3'b000} +: 8] : 8'd0;
        ext_dec        = ext_count_reg - 4'd1;
        key_inc        = key_index_reg + 2'd1;
        result         = '0;

        case (phase_cur)
            PH_HDR0:
            begin
                fin_next       = b[7];
                opcode_next    = b[3:0];
                mask_next      = 1'b0;
                length_next    = '0;
                mask_key_next  = '0;
                key_index_next = 2'd0;
                remaining_next = '0;
                ext_count_next = 4'd0;
                phase_next     = PH_HDR1;
            end
            PH_HDR1:
            begin
                mask_next = b[7];
                if (b[6:0] == wsfd_pkg::LEN_CODE_16)
                begin
                    length_next    = '0;
                    ext_count_next = wsfd_pkg::EXT_BYTES_16;
                    phase_next     = PH_EXT;
                end
                else if (b[6:0] == wsfd_pkg::LEN_CODE_64)
                begin
                    length_next    = '0;
                    ext_count_next = wsfd_pkg::EXT_BYTES_64;
                    phase_next     = PH_EXT;
                end
                else
                begin
                    length_next    = {57'd0, b[6:0]};
                    key_index_next = 2'd0;
                    if (b[7])
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        remaining_next = {57'd0, b[6:0]};
                        phase_next     = (b[6:0] != 7'd0) ? PH_PAY : PH_DONE;
                    end
                end
            end
            PH_EXT:
            begin
                length_next    = {length_reg[55:0], b};
                ext_count_next = ext_dec;
                if (ext_dec == 4'd0)
                begin
                    key_index_next = 2'd0;
                    if (mask_reg)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        remaining_next = {length_reg[55:0], b};
                        phase_next     = ({length_reg[55:0], b} != 64'd0) ? PH_PAY : PH_DONE;
                    end
                end
            end
            PH_KEY:
            begin
                mask_key_next  = {mask_key_reg[23:0], b};
                key_index_next = key_inc;
                if (key_inc == 2'd0)
                begin
                    remaining_next = length_reg;
                    phase_next     = (length_reg != 64'd0) ? PH_PAY : PH_DONE;
                end
            end
            PH_PAY:
            begin
                result.payload_byte = b ^ key_byte;
                result.is_payload   = 1'b1;
                key_index_next      = key_inc;
                remaining_next      = remaining_reg - 64'd1;
                if (remaining_reg == 64'd1)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                // trailing bytes and unused codes: nothing changes
                phase_next = phase_cur;
            end
        endcase

        before_hdr = (phase_cur == PH_HDR0) || (phase_cur == PH_HDR1) ||
                     (phase_cur == PH_EXT)  || (phase_cur == PH_KEY);
        after_hdr  = (phase_next == PH_PAY) || (phase_next == PH_DONE);
        still_hdr  = (phase_next == PH_HDR0) || (phase_next == PH_HDR1) ||
                     (phase_next == PH_EXT)  || (phase_next == PH_KEY);

        result.header_done    = before_hdr && after_hdr;
        result.fin_bit        = fin_next;
        result.frame_opcode   = opcode_next;
        result.masked         = mask_next;
        result.payload_length = length_next[31:0];

        if (item.buffer_end)
        begin
            result.status_valid = 1'b1;
            if (still_hdr)
            begin
                result.status = wsfd_pkg::ST_TRUNCATED;
            end
            else if (phase_next == PH_PAY)
            begin
                result.status = wsfd_pkg::ST_OVERRUN;
            end
            else if (!wsfd_pkg::opcode_known(opcode_next))
            begin
                result.status = wsfd_pkg::ST_BAD_OP;
            end
            else
            begin
                result.status = wsfd_pkg::ST_OK;
            end
            phase_next = PH_HDR0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            ext_count_reg <= 4'd0;
            fin_reg       <= 1'b0;
            opcode_reg    <= 4'd0;
            mask_reg      <= 1'b0;
            length_reg    <= '0;
            mask_key_reg  <= '0;
            key_index_reg <= 2'd0;
            remaining_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            ext_count_reg <= ext_count_next;
            fin_reg       <= fin_next;
            opcode_reg    <= opcode_next;
            mask_reg      <= mask_next;
            length_reg    <= length_next;
            mask_key_reg  <= mask_key_next;
            key_index_reg <= key_index_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

// ===== rtl/wsfd_out_stage.sv =====
module wsfd_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_valid,
    input  wsfd_pkg::wsfd_result_t load_result,
    output logic                   can_load,
    output logic                   out_valid,
    input  logic                   out_ready,
    output wsfd_pkg::wsfd_result_t result
);

    logic                   valid_reg;
    logic                   valid_next;
    wsfd_pkg::wsfd_result_t result_reg;

    // register takes a new item when empty or being drained
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = can_load ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load_valid)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/wsfd_checker.sv =====
module wsfd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] payload_byte,
    input logic       is_payload,
    input logic       header_done,
    input logic       status_valid,
    input logic [1:0] status
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte) &&
        $stable(status) && $stable(is_payload))
        else $error("output item changed while stalled");

    // a byte cannot both finish the header and be payload
    a_hdr_pay_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_payload && header_done))
        else $error("header_done and is_payload together");

    // non-payload bytes carry a zero data byte
    a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_payload |-> payload_byte == 8'd0)
        else $error("payload_byte set on non-payload item");

    // status only meaningful on buffer end
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status_valid |-> status == wsfd_pkg::ST_OK)
        else $error("status set without status_valid");

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (.*);
